FILE: rtl/core/srsa_pkg.sv
// Shared types and constants of the scoped register stack allocator.
package srsa_pkg;

  localparam int MAX_REGS_DEF = 255;
  localparam int HASH_W       = 32;
  localparam int TYPE_W       = 8;
  localparam int IDX_W        = 8;
  localparam int IN_DATA_W    = 56;
  localparam int OUT_DATA_W   = 48;

  typedef enum logic [3:0] {
    CMD_PUSH_TEMP       = 4'd0,
    CMD_POP_TEMP_TO     = 4'd1,
    CMD_POP_TEMP_PAST   = 4'd2,
    CMD_PUSH_NAMED      = 4'd3,
    CMD_POP_NAMED_TO    = 4'd4,
    CMD_POP_NAMED_PAST  = 4'd5,
    CMD_LOOKUP          = 4'd6,
    CMD_CLASSIFY        = 4'd7,
    CMD_CLEAR           = 4'd8
  } cmd_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_t;

  // Search probe handed from cell to cell.
  typedef struct packed {
    logic              vld;
    logic [HASH_W-1:0] hash;
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [TYPE_W-1:0] vtype;
  } probe_t;

  // Broadcast write of a named entry.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [HASH_W-1:0] hash;
    logic [TYPE_W-1:0] vtype;
  } wr_t;

endpackage

FILE: rtl/core/scoped_register_stack_allocator_unit.sv
// Top level of the scoped register stack allocator: command control and entry chain.
// Counter commands, and a push named that cannot succeed, register their result
//   in the cycle after the item is accepted; lookup, and a push named that can
//   succeed, send a probe from the head register down the chain of MAX_REGS cells,
//   one cell a cycle, and register their result when the probe leaves the last cell.
// One item in flight; the next item is taken in the cycle its predecessor's result is taken.
// Reset (rst_n low, synchronous): counts and high-water mark go to zero; table
//   entries stay undefined until written by push named.
module scoped_register_stack_allocator_unit import srsa_pkg::*; #(
  parameter int MAX_REGS = MAX_REGS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Fields from bit 0 up: command[3:0], name_hash[35:4], var_type[43:36],
  // slot_index[51:44], zero fill[55:52].
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0 up: ok[0], result_index[8:1], found_type[16:9], is_named[17],
  // named_count[25:18], temp_count[33:26], max_allocated[41:34], zero fill[47:42].
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready
);

  localparam logic [IDX_W:0] MAX_W = (IDX_W + 1)'(MAX_REGS);

  // Unpack the input item.
  cmd_t              in_cmd;
  logic [HASH_W-1:0] in_hash;
  logic [TYPE_W-1:0] in_vtype;
  logic [IDX_W-1:0]  in_idx;

  assign in_cmd   = cmd_t'(in_tdata[3:0]);
  assign in_hash  = in_tdata[35:4];
  assign in_vtype = in_tdata[43:36];
  assign in_idx   = in_tdata[51:44];

  // Control and counts.
  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [TYPE_W-1:0] vtype_r, vtype_nxt;
  logic [IDX_W-1:0]  named_r, named_nxt;
  logic [IDX_W-1:0]  temp_r, temp_nxt;
  logic [IDX_W-1:0]  hw_r, hw_nxt;

  // Output register.
  logic              out_vld_r, out_vld_nxt;
  logic              ok_r, ok_nxt;
  logic [IDX_W-1:0]  ridx_r, ridx_nxt;
  logic [TYPE_W-1:0] ftype_r, ftype_nxt;
  logic              isn_r, isn_nxt;
  logic [IDX_W-1:0]  nc_r, tc_r, ma_r;
  logic              load;

  // Chain.
  probe_t            head_r, head_nxt;
  probe_t            chain_w [0:MAX_REGS];
  probe_t            tail;
  wr_t               wr;

  logic              accept;
  logic [IDX_W:0]    total;
  logic [IDX_W:0]    idx_w;

  assign in_tready = (state_r == ST_IDLE) && (!out_vld_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign total     = {1'b0, named_r} + {1'b0, temp_r};
  assign idx_w     = {1'b0, in_idx};
  assign tail      = chain_w[MAX_REGS];

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    vtype_nxt   = vtype_r;
    named_nxt   = named_r;
    temp_nxt    = temp_r;
    hw_nxt      = hw_r;
    out_vld_nxt = out_vld_r && !out_tready;
    ok_nxt      = ok_r;
    ridx_nxt    = ridx_r;
    ftype_nxt   = ftype_r;
    isn_nxt     = isn_r;
    load        = 1'b0;
    head_nxt    = '0;
    wr          = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_cmd;
          vtype_nxt = in_vtype;
          ok_nxt    = 1'b0;
          ridx_nxt  = '0;
          ftype_nxt = '0;
          isn_nxt   = 1'b0;
          load      = 1'b1;
          case (in_cmd)
            CMD_PUSH_TEMP: begin
              if (total < MAX_W) begin
                ridx_nxt = total[IDX_W-1:0];
                temp_nxt = temp_r + 1'b1;
                if ({1'b0, hw_r} < total + 1'b1) begin
                  hw_nxt = IDX_W'(total + 1'b1);
                end
                ok_nxt = 1'b1;
              end
            end
            CMD_POP_TEMP_TO: begin
              if (in_idx >= named_r && idx_w <= total && idx_w + 1'b1 <= MAX_W) begin
                temp_nxt = in_idx - named_r + 1'b1;
                ok_nxt   = 1'b1;
              end
            end
            CMD_POP_TEMP_PAST: begin
              if (in_idx >= named_r && idx_w <= total) begin
                temp_nxt = in_idx - named_r;
                ok_nxt   = 1'b1;
              end
            end
            CMD_PUSH_NAMED: begin
              // Launch a duplicate search only when the push could succeed.
              if (temp_r == '0 && {1'b0, named_r} < MAX_W) begin
                head_nxt.vld  = 1'b1;
                head_nxt.hash = in_hash;
                state_nxt     = ST_SEARCH;
                load          = 1'b0;
              end
            end
            CMD_POP_NAMED_TO: begin
              if (temp_r == '0 && in_idx < named_r) begin
                named_nxt = in_idx + 1'b1;
                ok_nxt    = 1'b1;
              end
            end
            CMD_POP_NAMED_PAST: begin
              if (temp_r == '0 && in_idx <= named_r) begin
                named_nxt = in_idx;
                ok_nxt    = 1'b1;
              end
            end
            CMD_LOOKUP: begin
              head_nxt.vld  = 1'b1;
              head_nxt.hash = in_hash;
              state_nxt     = ST_SEARCH;
              load          = 1'b0;
            end
            CMD_CLASSIFY: begin
              isn_nxt = (in_idx < named_r);
              ok_nxt  = 1'b1;
            end
            CMD_CLEAR: begin
              named_nxt = '0;
              temp_nxt  = '0;
              hw_nxt    = '0;
              ok_nxt    = 1'b1;
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        // Collect the probe at the end of the chain.
        if (tail.vld) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
          ok_nxt    = 1'b0;
          ridx_nxt  = '0;
          ftype_nxt = '0;
          isn_nxt   = 1'b0;
          if (cmd_r == CMD_LOOKUP) begin
            ok_nxt    = tail.found;
            ridx_nxt  = tail.idx;
            ftype_nxt = tail.vtype;
          end else if (!tail.found) begin
            wr.en     = 1'b1;
            wr.idx    = named_r;
            wr.hash   = tail.hash;
            wr.vtype  = vtype_r;
            ridx_nxt  = named_r;
            named_nxt = named_r + 1'b1;
            ok_nxt    = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      named_r   <= '0;
      temp_r    <= '0;
      hw_r      <= '0;
      out_vld_r <= 1'b0;
      head_r.vld <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      named_r   <= named_nxt;
      temp_r    <= temp_nxt;
      hw_r      <= hw_nxt;
      out_vld_r <= out_vld_nxt;
      head_r.vld <= head_nxt.vld;
    end
    cmd_r        <= cmd_nxt;
    vtype_r      <= vtype_nxt;
    ok_r         <= ok_nxt;
    ridx_r       <= ridx_nxt;
    ftype_r      <= ftype_nxt;
    isn_r        <= isn_nxt;
    head_r.hash  <= head_nxt.hash;
    head_r.found <= head_nxt.found;
    head_r.idx   <= head_nxt.idx;
    head_r.vtype <= head_nxt.vtype;
    // Counts shown are those after the command.
    if (load) begin
      nc_r <= named_nxt;
      tc_r <= temp_nxt;
      ma_r <= hw_nxt;
    end
  end

  // Chain of table cells; cell i holds entry i.
  assign chain_w[0] = head_r;

  for (genvar g = 0; g < MAX_REGS; g++) begin : g_cell
    srsa_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr        (wr),
      .limit     (named_r),
      .probe_in  (chain_w[g]),
      .probe_out (chain_w[g+1])
    );
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, ma_r, tc_r, nc_r, isn_r, ftype_r, ridx_r, ok_r};

  // The stack never holds more registers than the table has cells.
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total <= MAX_W)
    else $error("named plus temporaries exceed table depth");

  // A probe leaves the chain only while a search is pending.
  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> state_r == ST_SEARCH)
    else $error("probe left chain outside a search");

  // A table write grows the named count by exactly one.
  a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> named_r == $past(named_r) + 1'b1)
    else $error("table write without named count increment");

  // A new item is never taken while an untaken result would be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (!out_vld_r || out_tready))
    else $error("result overwritten before it was taken");

endmodule

FILE: rtl/core/srsa_cell.sv
// One entry of the named table: holds a hash and type, matches a passing probe.
module srsa_cell import srsa_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wr_t              wr,
  input  logic [IDX_W-1:0] limit,
  input  probe_t           probe_in,
  output probe_t           probe_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [HASH_W-1:0] hash_r;
  logic [TYPE_W-1:0] vtype_r;
  probe_t            probe_r;
  probe_t            probe_nxt;
  logic              hit;

  // Hold the entry; only live entries (below limit) take part in a match.
  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == MY_IDX) begin
      hash_r  <= wr.hash;
      vtype_r <= wr.vtype;
    end
  end

  assign hit = probe_in.vld && !probe_in.found && (MY_IDX < limit) &&
               (hash_r == probe_in.hash);

  always_comb begin
    probe_nxt = probe_in;
    if (hit) begin
      probe_nxt.found = 1'b1;
      probe_nxt.idx   = MY_IDX;
      probe_nxt.vtype = vtype_r;
    end
  end

  // Advance the probe one cell per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else begin
      probe_r.vld <= probe_nxt.vld;
    end
    probe_r.hash  <= probe_nxt.hash;
    probe_r.found <= probe_nxt.found;
    probe_r.idx   <= probe_nxt.idx;
    probe_r.vtype <= probe_nxt.vtype;
  end

  assign probe_out = probe_r;

endmodule
